// ===== rtl/core/fqs_pkg.sv =====
// Package: shared types and constants of the searchable FIFO queue.
package fqs_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int REQ_VALUE_W        = 32;
   localparam int RSP_DATA_W         = 32;
   localparam int RSP_POS_W          = 4;
   localparam int RSP_COUNT_W        = 5;
   localparam int CMDQ_DEPTH         = 2;
   localparam int CMDQ_PTR_W         = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_FILL_W        = $clog2(CMDQ_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_PUSH   = 2'd0,
      CMD_POP    = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_DUMP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_WALK = 1'b1
   } state_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [REQ_VALUE_W-1:0]  value;
   } op_type;

endpackage

// ===== rtl/core/fqs_front.sv =====
// Front end: request transfer, command decode and a short command queue.
module fqs_front
   import fqs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_command,
   input  logic [REQ_VALUE_W-1:0] req_value,
   output logic                   op_valid,
   output op_type                 op,
   input  logic                   op_pop
);

   op_type                 slot_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_FILL_W-1:0] fill_ff, fill_in;
   logic                   accept;
   op_type                 new_op;

   assign busy     = (fill_ff == CMDQ_FILL_W'(CMDQ_DEPTH));
   assign accept   = start && !busy;
   assign op_valid = (fill_ff != '0);
   assign op       = slot_ff[rd_ptr_ff];

   always_comb begin
      new_op.cmd   = cmd_type'(req_command);
      new_op.value = req_value;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (op_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      fill_in = fill_ff + CMDQ_FILL_W'(accept) - CMDQ_FILL_W'(op_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wr_ptr_ff] <= new_op;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      op_pop |-> op_valid)
      else $error("command queue popped while empty");

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CMDQ_FILL_W'(CMDQ_DEPTH))
      else $error("command queue overfilled");

   assert property (@(posedge clock) disable iff (reset)
      (accept && !op_pop) |=> (fill_ff == $past(fill_ff) + 1'b1))
      else $error("command queue lost a transfer");

endmodule

// ===== rtl/core/fqs_back.sv =====
// Back end: ring store, head/tail/occupancy and the walk sequencer.
module fqs_back
   import fqs_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   op_valid,
   input  op_type                 op,
   output logic                   op_pop,
   output logic                   rsp_strobe,
   output logic [1:0]             rsp_status,
   output logic [RSP_DATA_W-1:0]  rsp_data_out,
   output logic [RSP_POS_W-1:0]   rsp_position,
   output logic [RSP_COUNT_W-1:0] rsp_count,
   output logic                   rsp_last
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic                  mem_we;
   logic [DATA_WIDTH-1:0] value_ext;

   state_type             state_ff, state_in;
   cmd_type               op_cmd_ff, op_cmd_in;
   logic [DATA_WIDTH-1:0] op_val_ff, op_val_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [IDX_W-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]      occ_ff, occ_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      ptr_ff, ptr_in;
   logic                  last_idx;

   logic                  emit;
   status_type            emit_status;
   logic [DATA_WIDTH-1:0] emit_data;
   logic [IDX_W-1:0]      emit_pos;
   logic [CNT_W-1:0]      emit_cnt;
   logic                  emit_last;

   logic                   rsp_strobe_ff;
   status_type             rsp_status_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [RSP_POS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [RSP_COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                   rsp_last_ff;

   generate
      if (DATA_WIDTH <= REQ_VALUE_W) begin : g_val_trunc
         assign value_ext = op.value[DATA_WIDTH-1:0];
      end else begin : g_val_sext
         assign value_ext = {{(DATA_WIDTH - REQ_VALUE_W){op.value[REQ_VALUE_W-1]}}, op.value};
      end
      if (DATA_WIDTH >= RSP_DATA_W) begin : g_dout_trunc
         assign rsp_data_in = emit_data[RSP_DATA_W-1:0];
      end else begin : g_dout_zext
         assign rsp_data_in = {{(RSP_DATA_W - DATA_WIDTH){1'b0}}, emit_data};
      end
      if (IDX_W >= RSP_POS_W) begin : g_pos_trunc
         assign rsp_pos_in = emit_pos[RSP_POS_W-1:0];
      end else begin : g_pos_zext
         assign rsp_pos_in = {{(RSP_POS_W - IDX_W){1'b0}}, emit_pos};
      end
      if (CNT_W >= RSP_COUNT_W) begin : g_cnt_trunc
         assign rsp_count_in = emit_cnt[RSP_COUNT_W-1:0];
      end else begin : g_cnt_zext
         assign rsp_count_in = {{(RSP_COUNT_W - CNT_W){1'b0}}, emit_cnt};
      end
   endgenerate

   assign last_idx = (CNT_W'(idx_ff) + CNT_W'(1) == occ_ff);

   always_comb begin
      state_in    = state_ff;
      op_cmd_in   = op_cmd_ff;
      op_val_in   = op_val_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      occ_in      = occ_ff;
      idx_in      = idx_ff;
      ptr_in      = ptr_ff;
      rd_addr     = ptr_ff;
      mem_we      = 1'b0;
      op_pop      = 1'b0;
      emit        = 1'b0;
      emit_status = ST_OK;
      emit_data   = '0;
      emit_pos    = '0;
      emit_cnt    = occ_ff;
      emit_last   = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (op_valid) begin
               op_pop    = 1'b1;
               op_cmd_in = op.cmd;
               op_val_in = value_ext;
               rd_addr   = head_ff;
               ptr_in    = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
               idx_in    = '0;
               unique case (op.cmd)
                  CMD_PUSH: begin
                     emit = 1'b1;
                     if (occ_ff == CNT_W'(DEPTH)) begin
                        emit_status = ST_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        tail_in  = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
                        occ_in   = occ_ff + 1'b1;
                        emit_cnt = occ_ff + 1'b1;
                     end
                  end
                  CMD_POP, CMD_DUMP: begin
                     if (occ_ff == '0) begin
                        emit        = 1'b1;
                        emit_status = ST_EMPTY;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  CMD_SEARCH: begin
                     if (occ_ff == '0) begin
                        emit        = 1'b1;
                        emit_status = ST_NOT_FOUND;
                        emit_data   = value_ext;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
               endcase
            end
         end
         S_WALK: begin
            ptr_in = (ptr_ff == LAST_SLOT) ? '0 : ptr_ff + 1'b1;
            idx_in = idx_ff + 1'b1;
            unique case (op_cmd_ff)
               CMD_POP: begin
                  emit      = 1'b1;
                  emit_data = rd_data_ff;
                  head_in   = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
                  occ_in    = occ_ff - 1'b1;
                  emit_cnt  = occ_ff - 1'b1;
                  state_in  = S_IDLE;
               end
               CMD_SEARCH: begin
                  emit_data = op_val_ff;
                  if (rd_data_ff == op_val_ff) begin
                     emit     = 1'b1;
                     emit_pos = idx_ff;
                     state_in = S_IDLE;
                  end else if (last_idx) begin
                     emit        = 1'b1;
                     emit_status = ST_NOT_FOUND;
                     state_in    = S_IDLE;
                  end
               end
               CMD_DUMP: begin
                  emit      = 1'b1;
                  emit_data = rd_data_ff;
                  emit_last = last_idx;
                  if (last_idx) begin
                     state_in = S_IDLE;
                  end
               end
               CMD_PUSH: begin
                  state_in = S_IDLE;
               end
            endcase
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         occ_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         occ_ff        <= occ_in;
         rsp_strobe_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      op_cmd_ff     <= op_cmd_in;
      op_val_ff     <= op_val_in;
      idx_ff        <= idx_in;
      ptr_ff        <= ptr_in;
      rsp_status_ff <= emit_status;
      rsp_data_ff   <= rsp_data_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= emit_last;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[tail_ff] <= value_ext;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_last     = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(DEPTH))
      else $error("occupancy above depth");

   assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0 || occ_ff == CNT_W'(DEPTH)) |-> (head_ff == tail_ff))
      else $error("head and tail disagree with occupancy");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && op_cmd_ff == CMD_DUMP) |=> rsp_strobe_ff)
      else $error("dump skipped a cycle");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> !op_pop)
      else $error("command taken during a walk");

endmodule

// ===== rtl/core/fifo_queue_with_search_top.sv =====
// Top level: searchable FIFO queue, front end and back end joined by a command queue.
// Push and empty/full reports are settled at decode; pop, search and dump walk
// the ring store from head; a dump gives one result per entry, rsp_last on the last.
// Throughput: push 1 per cycle outside walks; no new command is taken during a walk,
// and the single read port of the ring store gives one entry per cycle to a walk.
// Synchronous reset clears occupancy, head and tail; store contents stay undefined.
// Results appear for one cycle on rsp_strobe; the receiver cannot stall.
module fifo_queue_with_search_top
   import fqs_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_command,
   input  logic signed [REQ_VALUE_W-1:0] req_value,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_status,
   output logic signed [RSP_DATA_W-1:0]  rsp_data_out,
   output logic [RSP_POS_W-1:0]          rsp_position,
   output logic [RSP_COUNT_W-1:0]        rsp_count,
   output logic                          rsp_last
);

   logic                  op_valid;
   op_type                op;
   logic                  op_pop;
   logic [RSP_DATA_W-1:0] data_out;

   fqs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_command (req_command),
      .req_value   (req_value),
      .op_valid    (op_valid),
      .op          (op),
      .op_pop      (op_pop)
   );

   fqs_back #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .op_valid     (op_valid),
      .op           (op),
      .op_pop       (op_pop),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_data_out (data_out),
      .rsp_position (rsp_position),
      .rsp_count    (rsp_count),
      .rsp_last     (rsp_last)
   );

   assign rsp_data_out = data_out;

endmodule

// ===== tb/sv/fifo_queue_with_search_checker.sv =====
// Checker: tracks queue contents from accepted commands and compares every response.
`timescale 1ns / 1ps

module fifo_queue_with_search_checker
   import fqs_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  logic [1:0]             req_command,
   input  logic [REQ_VALUE_W-1:0] req_value,
   input  logic                   rsp_strobe,
   input  logic [1:0]             rsp_status,
   input  logic [RSP_DATA_W-1:0]  rsp_data_out,
   input  logic [RSP_POS_W-1:0]   rsp_position,
   input  logic [RSP_COUNT_W-1:0] rsp_count,
   input  logic                   rsp_last,
   output int                     fail_count,
   output int                     owed_count
);

   typedef struct {
      status_type             status;
      logic [RSP_DATA_W-1:0]  data;
      logic [RSP_POS_W-1:0]   pos;
      logic [RSP_COUNT_W-1:0] cnt;
      logic                   last;
   } rsp_rec;

   logic [RSP_DATA_W-1:0] ring_mem [DEPTH];
   int unsigned           head_slot;
   int unsigned           tail_slot;
   int unsigned           fill_level;
   rsp_rec                owed_rsps [$];

   task automatic owe(input status_type st, input logic [RSP_DATA_W-1:0] d,
                      input int unsigned p, input logic lst);
      rsp_rec r;
      r.status = st;
      r.data   = d;
      r.pos    = p[RSP_POS_W-1:0];
      r.cnt    = fill_level[RSP_COUNT_W-1:0];
      r.last   = lst;
      owed_rsps.push_back(r);
   endtask

   task automatic run_queue_command(input cmd_type c, input logic [RSP_DATA_W-1:0] v);
      int unsigned           i;
      int unsigned           hit_pos;
      bit                    hit;
      logic [RSP_DATA_W-1:0] d;
      hit     = 1'b0;
      hit_pos = 0;
      case (c)
         CMD_PUSH: begin
            if (fill_level >= DEPTH) begin
               owe(ST_FULL, '0, 0, 1'b1);
            end else begin
               ring_mem[tail_slot] = v;
               tail_slot = (tail_slot + 1) % DEPTH;
               fill_level++;
               owe(ST_OK, '0, 0, 1'b1);
            end
         end
         CMD_POP: begin
            if (fill_level == 0) begin
               owe(ST_EMPTY, '0, 0, 1'b1);
            end else begin
               d = ring_mem[head_slot];
               head_slot = (head_slot + 1) % DEPTH;
               fill_level--;
               owe(ST_OK, d, 0, 1'b1);
            end
         end
         CMD_SEARCH: begin
            for (i = 0; i < fill_level; i++) begin
               if (!hit && ring_mem[(head_slot + i) % DEPTH] == v) begin
                  hit     = 1'b1;
                  hit_pos = i;
               end
            end
            if (hit) owe(ST_OK, v, hit_pos, 1'b1);
            else owe(ST_NOT_FOUND, v, 0, 1'b1);
         end
         default: begin
            if (fill_level == 0) begin
               owe(ST_EMPTY, '0, 0, 1'b1);
            end else begin
               for (i = 0; i < fill_level; i++)
                  owe(ST_OK, ring_mem[(head_slot + i) % DEPTH], 0, i + 1 == fill_level);
            end
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [RSP_DATA_W-1:0] want,
                              input logic [RSP_DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_rec r;
      if (reset) begin
         fail_count = 0;
         head_slot  = 0;
         tail_slot  = 0;
         fill_level = 0;
         owed_rsps.delete();
      end else begin
         if (rsp_strobe) begin
            if (owed_rsps.size() == 0) begin
               $error("unexpected response transfer: status %0d data %0h",
                      rsp_status, rsp_data_out);
               fail_count++;
            end else begin
               r = owed_rsps.pop_front();
               check_field("status", r.status, rsp_status);
               check_field("data_out", r.data, rsp_data_out);
               check_field("position", r.pos, rsp_position);
               check_field("count", r.cnt, rsp_count);
               check_field("last", r.last, rsp_last);
            end
         end
         if (start && !busy)
            run_queue_command(cmd_type'(req_command), req_value);
      end
      owed_count = owed_rsps.size();
   end

endmodule

// ===== tb/sv/fifo_queue_with_search_top_test.sv =====
// Testbench top: clock, reset, command stimulus and final verdict for the queue.
`timescale 1ns / 1ps

module fifo_queue_with_search_top_test;
   import fqs_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_OPS  = 125;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [1:0]                    req_command;
   logic signed [REQ_VALUE_W-1:0] req_value;
   logic                          rsp_strobe;
   logic [1:0]                    rsp_status;
   logic signed [RSP_DATA_W-1:0]  rsp_data_out;
   logic [RSP_POS_W-1:0]          rsp_position;
   logic [RSP_COUNT_W-1:0]        rsp_count;
   logic                          rsp_last;
   int                            fail_count;
   int                            owed_count;
   int                            cycle_count = 0;
   int                            burst_left;
   logic [REQ_VALUE_W-1:0]        value_pool [8];

   fifo_queue_with_search_top dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_command  (req_command),
      .req_value    (req_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_data_out (rsp_data_out),
      .rsp_position (rsp_position),
      .rsp_count    (rsp_count),
      .rsp_last     (rsp_last)
   );

   fifo_queue_with_search_checker checker_inst (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_command  (req_command),
      .req_value    (req_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_data_out (rsp_data_out),
      .rsp_position (rsp_position),
      .rsp_count    (rsp_count),
      .rsp_last     (rsp_last),
      .fail_count   (fail_count),
      .owed_count   (owed_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // One command transfer; start stays high within a burst, drops for a gap after it.
   task automatic issue(input cmd_type c, input logic [REQ_VALUE_W-1:0] v);
      start       <= 1'b1;
      req_command <= c;
      req_value   <= v;
      do @(posedge clock); while (busy);
      burst_left--;
      if (burst_left <= 0) begin
         start <= 1'b0;
         if ($urandom_range(3, 0) == 0) repeat ($urandom_range(24, 1)) @(posedge clock);
         else repeat ($urandom_range(3, 1)) @(posedge clock);
         burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(30, 10)
                                                  : $urandom_range(6, 1);
      end
   endtask

   function automatic logic [REQ_VALUE_W-1:0] pick_value();
      if ($urandom_range(9, 0) < 7) return value_pool[$urandom_range(7, 0)];
      return $urandom();
   endfunction

   initial begin
      logic [REQ_VALUE_W-1:0] fill_vals [16];
      cmd_type                c;
      int                     pick;
      int                     mode;
      reset       = 1'b1;
      start       = 1'b0;
      req_command = CMD_PUSH;
      req_value   = '0;
      burst_left  = 1;
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7FFF_FFFF;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < 8; i++) value_pool[i] = $urandom();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty queue cases
      issue(CMD_POP, 32'h0);
      issue(CMD_DUMP, 32'h0);
      issue(CMD_SEARCH, 32'h0);

      // fill to capacity with extremes and a duplicate, then overflow
      fill_vals[0] = 32'h8000_0000;
      fill_vals[1] = 32'h7FFF_FFFF;
      fill_vals[2] = 32'h0000_0000;
      fill_vals[3] = 32'hFFFF_FFFF;
      fill_vals[4] = 32'hAAAA_AAAA;
      fill_vals[5] = 32'h5555_5555;
      for (int i = 6; i < 15; i++) fill_vals[i] = $urandom();
      fill_vals[7]  = 32'hFFFF_FFFF;
      fill_vals[15] = 32'h1234_5678;
      for (int i = 0; i < 16; i++) issue(CMD_PUSH, fill_vals[i]);
      issue(CMD_PUSH, 32'hDEAD_BEEF);
      issue(CMD_SEARCH, fill_vals[0]);
      issue(CMD_SEARCH, fill_vals[3]);
      issue(CMD_SEARCH, fill_vals[15]);
      issue(CMD_DUMP, 32'h0);
      issue(CMD_POP, 32'h0);

      // random traffic in randomly chosen fill-heavy, drain-heavy and mixed phases
      mode = 0;
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n % 20 == 0) mode = $urandom_range(2, 0);
         pick = $urandom_range(99, 0);
         case (mode)
            0: c = (pick < 60) ? CMD_PUSH : (pick < 75) ? CMD_POP :
                   (pick < 92) ? CMD_SEARCH : CMD_DUMP;
            1: c = (pick < 15) ? CMD_PUSH : (pick < 75) ? CMD_POP :
                   (pick < 92) ? CMD_SEARCH : CMD_DUMP;
            default: c = (pick < 35) ? CMD_PUSH : (pick < 65) ? CMD_POP :
                         (pick < 90) ? CMD_SEARCH : CMD_DUMP;
         endcase
         if (c == CMD_PUSH || c == CMD_SEARCH) issue(c, pick_value());
         else issue(c, $urandom());
      end
      start <= 1'b0;

      do @(negedge clock); while (owed_count != 0);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/fqs_pkg.sv
rtl/core/fqs_front.sv
rtl/core/fqs_back.sv
rtl/core/fifo_queue_with_search_top.sv
tb/sv/fifo_queue_with_search_checker.sv
tb/sv/fifo_queue_with_search_top_test.sv
